// ----- src/avm_pkg.sv -----
// ----------------------------------------------------------------------------
// avm_pkg: shared types, constants and tables for the voltmeter display driver
// Holds the sample group size, the constant multipliers used for exact
// division, the seven-segment table and the back-end state encoding.
// ----------------------------------------------------------------------------
`default_nettype none

package avm_pkg;

  // Samples averaged into one reading (1 to 16).
  localparam int SAMPLES   = 10;

  localparam int SAMPLE_W  = 10;
  localparam int SUM_W     = 14;
  localparam int CNT_W     = 6;

  // Exact floor(sum / SAMPLES) for every 14-bit sum by a rounded-up reciprocal.
  localparam int RECIP_SH  = 18;
  localparam int RECIP     = (2**RECIP_SH + SAMPLES - 1) / SAMPLES;
  localparam int RECIP_W   = $clog2(RECIP + 1);
  localparam int AVG_PW    = SUM_W + RECIP_W;

  // Millivolts: floor(avg * 625 / 128).
  localparam int MV_MUL_W  = 10;
  localparam logic [MV_MUL_W-1:0] MV_MUL = MV_MUL_W'(625);
  localparam int MV_SH     = 7;
  localparam int MV_PW     = SUM_W + MV_MUL_W;
  localparam int MV_W      = 17;

  // Exact floor(v / 10) for v below 81920.
  localparam int DIV10_W   = 16;
  localparam logic [DIV10_W-1:0] DIV10_MUL = DIV10_W'(52429);
  localparam int DIV10_SH  = 19;
  localparam int DIV10_PW  = MV_W + DIV10_W;

  localparam int WORD_W    = 16;
  localparam int BIT_W     = 4;
  localparam logic [BIT_W-1:0] LAST_BIT = BIT_W'(WORD_W - 1);

  localparam int Q_DEPTH   = 2;
  localparam int Q_AW      = $clog2(Q_DEPTH);

  typedef logic [SUM_W-1:0] sum_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_AVG,
    BK_MV,
    BK_DIV10,
    BK_SEG,
    BK_SHIFT
  } bk_state_t;

  // Active-low segment patterns, bit 0 shifted out first.
  function automatic logic [7:0] seg_pattern(input logic [3:0] digit);
    logic [7:0] pat;
    case (digit)
      4'd0:    pat = 8'h03;
      4'd1:    pat = 8'h9F;
      4'd2:    pat = 8'h25;
      4'd3:    pat = 8'h0D;
      4'd4:    pat = 8'h99;
      4'd5:    pat = 8'h49;
      4'd6:    pat = 8'h41;
      4'd7:    pat = 8'h1F;
      4'd8:    pat = 8'h01;
      4'd9:    pat = 8'h09;
      default: pat = 8'hFF;
    endcase
    return pat;
  endfunction

endpackage

`default_nettype wire

// ----- src/avm_front.sv -----
// ----------------------------------------------------------------------------
// avm_front: sample accumulator
// Sums incoming samples and pushes the finished sum of each group into the
// reading queue.
// ----------------------------------------------------------------------------
`default_nettype none

module avm_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [avm_pkg::SAMPLE_W-1:0]  in_adc_sample,
  input  wire avm_pkg::q_stat_t              q_stat,
  output logic                               q_push,
  output avm_pkg::sum_t                      q_wdata
);
  import avm_pkg::*;

  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             accept;
  logic [SUM_W-1:0] sum_add;
  logic [CNT_W-1:0] count_add;
  logic             done;

  // Stalling on a full queue keeps a completing sample from being lost.
  assign in_stall  = q_stat.full;
  assign accept    = in_valid && !in_stall;
  assign sum_add   = sum_r + SUM_W'(in_adc_sample);
  assign count_add = count_r + CNT_W'(1);
  assign done      = (count_add >= CNT_W'(SAMPLES));

  assign q_push  = accept && done;
  assign q_wdata = sum_add;

  always_comb begin
    sum_nxt   = sum_r;
    count_nxt = count_r;
    if (accept) begin
      if (done) begin
        sum_nxt   = '0;
        count_nxt = '0;
      end else begin
        sum_nxt   = sum_add;
        count_nxt = count_add;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r   <= '0;
      count_r <= '0;
    end else begin
      sum_r   <= sum_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- src/avm_queue.sv -----
// ----------------------------------------------------------------------------
// avm_queue: two-entry reading queue
// Decouples the accumulator from the digit and serializer back end.
// ----------------------------------------------------------------------------
`default_nettype none

module avm_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire avm_pkg::sum_t     wdata,
  input  wire logic              pop,
  output avm_pkg::sum_t          rdata,
  output avm_pkg::q_stat_t       stat
);
  import avm_pkg::*;

  sum_t              mem_r [Q_DEPTH];
  logic [Q_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_AW:0]     fill_r, fill_nxt;
  logic              do_push;
  logic              do_pop;

  assign stat.full  = (fill_r == (Q_AW+1)'(Q_DEPTH));
  assign stat.empty = (fill_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rdata      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + Q_AW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + Q_AW'(1) : rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + (Q_AW+1)'(1);
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - (Q_AW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- src/avm_back.sv -----
// ----------------------------------------------------------------------------
// avm_back: digit extraction and serializer
// Turns a group sum into millivolts, picks the digit of the current display
// position and shifts out segment and digit-select bits.
// ----------------------------------------------------------------------------
`default_nettype none

module avm_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire avm_pkg::q_stat_t  q_stat,
  input  wire avm_pkg::sum_t     q_rdata,
  output logic                   q_pop,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   out_serial_data,
  output logic                   out_latch_after
);
  import avm_pkg::*;

  bk_state_t         state_r, state_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [SUM_W-1:0]  avg_r, avg_nxt;
  logic [MV_W-1:0]   v_r, v_nxt;
  logic [MV_W-1:0]   quo_r, quo_nxt;
  logic [1:0]        iter_r, iter_nxt;
  logic [1:0]        pos_r, pos_nxt;
  logic [WORD_W-1:0] word_r, word_nxt;
  logic [BIT_W-1:0]  bit_r, bit_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_data_r, out_data_nxt;
  logic              out_latch_r, out_latch_nxt;

  logic [AVG_PW-1:0]   avg_prod;
  logic [MV_PW-1:0]    mv_prod;
  logic [DIV10_PW-1:0] div_prod;
  logic [MV_W-1:0]     div_q;
  logic [MV_W-1:0]     rem_full;
  logic [3:0]          digit;
  logic [7:0]          sel_byte;
  logic                out_free;

  assign avg_prod = AVG_PW'(sum_r) * AVG_PW'(RECIP);
  assign mv_prod  = MV_PW'(avg_r) * MV_PW'(MV_MUL);
  assign div_prod = DIV10_PW'(v_r) * DIV10_PW'(DIV10_MUL);
  assign div_q    = MV_W'(div_prod >> DIV10_SH);
  // Remainder by ten: the quotient times ten is built from two shifts.
  assign rem_full = v_r - {quo_r[MV_W-4:0], 3'b000} - {quo_r[MV_W-2:0], 1'b0};
  assign digit    = rem_full[3:0];
  assign sel_byte = 8'h80 >> pos_r;
  assign out_free = !out_valid_r || !out_stall;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE:  if (!q_stat.empty) state_nxt = BK_AVG;
      BK_AVG:   state_nxt = BK_MV;
      BK_MV:    state_nxt = BK_DIV10;
      BK_DIV10: if (iter_r == 2'd0) state_nxt = BK_SEG;
      BK_SEG:   state_nxt = BK_SHIFT;
      BK_SHIFT: if (out_free && bit_r == LAST_BIT) state_nxt = BK_IDLE;
      default:  state_nxt = BK_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    q_pop         = 1'b0;
    sum_nxt       = sum_r;
    avg_nxt       = avg_r;
    v_nxt         = v_r;
    quo_nxt       = quo_r;
    iter_nxt      = iter_r;
    pos_nxt       = pos_r;
    word_nxt      = word_r;
    bit_nxt       = bit_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    out_latch_nxt = out_latch_r;
    case (state_r)
      BK_IDLE: begin
        if (!q_stat.empty) begin
          q_pop   = 1'b1;
          sum_nxt = q_rdata;
        end
      end
      BK_AVG: begin
        avg_nxt = SUM_W'(avg_prod >> RECIP_SH);
      end
      BK_MV: begin
        v_nxt    = MV_W'(mv_prod >> MV_SH);
        // Thousands needs three divisions by ten, units none.
        iter_nxt = ~pos_r;
      end
      BK_DIV10: begin
        if (iter_r == 2'd0) begin
          quo_nxt = div_q;
        end else begin
          v_nxt    = div_q;
          iter_nxt = iter_r - 2'd1;
        end
      end
      BK_SEG: begin
        word_nxt = {sel_byte, seg_pattern(digit)};
        bit_nxt  = '0;
      end
      BK_SHIFT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = word_r[0];
          out_latch_nxt = (bit_r == LAST_BIT);
          word_nxt      = word_r >> 1;
          bit_nxt       = bit_r + BIT_W'(1);
          if (bit_r == LAST_BIT) begin
            pos_nxt = pos_r + 2'd1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sum_r       <= sum_nxt;
    avg_r       <= avg_nxt;
    v_r         <= v_nxt;
    quo_r       <= quo_nxt;
    iter_r      <= iter_nxt;
    word_r      <= word_nxt;
    bit_r       <= bit_nxt;
    out_data_r  <= out_data_nxt;
    out_latch_r <= out_latch_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_serial_data = out_data_r;
  assign out_latch_after = out_latch_r;

endmodule

`default_nettype wire

// ----- src/adc_voltmeter_seven_segment_driver.sv -----
// ----------------------------------------------------------------------------
// adc_voltmeter_seven_segment_driver: multiplexed voltmeter display driver
// Averages converter samples, scales them to millivolts and shifts out the
// segment and digit-select bits of one display position per reading.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake            Payload
//  in_       input      in_valid/in_stall    in_adc_sample[9:0]
//  out_      output     out_valid/out_stall  out_serial_data, out_latch_after
//
// Samples are taken one per cycle while the two-entry reading queue has room;
// the input stalls only when that queue is full.
// Each reading goes through arithmetic (one reciprocal multiply, one scaling
// multiply, up to four divide-by-ten steps) and then 16 transactions on the
// output, one per cycle unless the output stalls.
// Synchronous active-low reset clears the sum, the count, the queue and the
// display position (thousands digit first).
// ----------------------------------------------------------------------------
`default_nettype none

module adc_voltmeter_seven_segment_driver (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [avm_pkg::SAMPLE_W-1:0]  in_adc_sample,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_serial_data,
  output logic                               out_latch_after
);
  import avm_pkg::*;

  q_stat_t q_stat;
  logic    q_push;
  logic    q_pop;
  sum_t    q_wdata;
  sum_t    q_rdata;

  avm_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_adc_sample (in_adc_sample),
    .q_stat        (q_stat),
    .q_push        (q_push),
    .q_wdata       (q_wdata)
  );

  avm_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  avm_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_stat          (q_stat),
    .q_rdata         (q_rdata),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_serial_data (out_serial_data),
    .out_latch_after (out_latch_after)
  );

endmodule

`default_nettype wire
